// File: sv/bis_pkg.sv
package bis_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd0;
    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd2;
    localparam logic [2:0] REG_X_STEP        = 3'd3;
    localparam logic [2:0] REG_Y_STEP        = 3'd4;

    // pixel format codes
    localparam logic [1:0] FMT_555 = 2'd0;
    localparam logic [1:0] FMT_565 = 2'd1;
    localparam logic [1:0] FMT_888 = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 24;
    localparam int SIZE_W     = 9;
    localparam int DEST_W     = 12;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;

    localparam logic [15:0] MASK_G555 = 16'h03E0;
    localparam logic [15:0] MASK_G565 = 16'h07E0;
    localparam logic [4:0]  MASK_5    = 5'h1F;

    typedef logic [CH_W-1:0] t_chan;
    typedef t_chan [2:0] t_rgb;

    // split a packed pixel into its three channels
    function automatic t_rgb unpack_px(input logic [1:0] fmt, input logic [PIX_W-1:0] p);
        t_rgb c;
        case (fmt)
            FMT_555: begin
                c[0] = {3'b0, p[14:10] & MASK_5};
                c[1] = {3'b0, 5'((p[15:0] & MASK_G555) >> 5)};
                c[2] = {3'b0, p[4:0]};
            end
            FMT_565: begin
                c[0] = {3'b0, p[15:11] & MASK_5};
                c[1] = {2'b0, 6'((p[15:0] & MASK_G565) >> 5)};
                c[2] = {3'b0, p[4:0]};
            end
            default: begin
                c[0] = p[23:16];
                c[1] = p[15:8];
                c[2] = p[7:0];
            end
        endcase
        return c;
    endfunction

    // pack three channels back into the configured layout
    function automatic logic [PIX_W-1:0] pack_px(input logic [1:0] fmt, input t_rgb c);
        logic [PIX_W-1:0] p;
        case (fmt)
            FMT_555: p = {9'b0, c[0][4:0], c[1][4:0], c[2][4:0]};
            FMT_565: p = {8'b0, c[0][4:0], c[1][5:0], c[2][4:0]};
            default: p = {c[0], c[1], c[2]};
        endcase
        return p;
    endfunction

endpackage

// File: sv/bilinear_image_scaler.sv
// channel  | direction | signals                                        | beat
// ---------+-----------+------------------------------------------------+---------------------
// command  | in        | i_start, o_busy, i_op, i_src_*, i_in_pixel,    | start && !busy
//          |           | i_dest_col, i_dest_row                         |
// result   | out       | o_valid, o_out_pixel                           | o_valid, one cycle
// config   | in        | i_cfg_we, i_cfg_idx, i_cfg_data                | i_cfg_we
//
// One command per clock; o_busy stays low. A request beat passes through the
// registered stages multiply, frame store read, horizontal blend, and vertical
// blend and pack, in that order; the frame store read is the second stage.
// Loads write the store in the same stage that requests read it, so order holds.
// Reset is synchronous, active low, and clears the pipeline and the registers.
// The receiver cannot stall: each result shows for exactly one cycle.
module bilinear_image_scaler #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_op,
    input  logic [7:0]                    i_src_col,
    input  logic [7:0]                    i_src_row,
    input  logic [31:0]                   i_in_pixel,
    input  logic [bis_pkg::DEST_W-1:0]    i_dest_col,
    input  logic [bis_pkg::DEST_W-1:0]    i_dest_row,
    input  logic                          i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_valid,
    output logic [bis_pkg::PIX_W-1:0]     o_out_pixel
);
    import bis_pkg::*;

    localparam int CW    = $clog2(MAX_SRC_WIDTH);
    localparam int RW    = $clog2(MAX_SRC_HEIGHT);
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = DEST_W + STEP_W;
    localparam int IW    = PW - FRAC_BITS;
    localparam int TW    = CH_W + FRAC_BITS + 1;
    localparam int VW    = TW + FRAC_BITS + 1;
    localparam logic [AW-1:0] ROW_PITCH = AW'(MAX_SRC_WIDTH);
    localparam logic [FRAC_BITS:0] ONE_FRAC = {1'b1, {FRAC_BITS{1'b0}}};

    // configuration registers
    logic [1:0]        r_fmt;
    logic [SIZE_W-1:0] r_src_w, r_src_h;
    logic [STEP_W-1:0] r_x_step, r_y_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_888;
            r_src_w  <= SIZE_W'(256);
            r_src_h  <= SIZE_W'(256);
            r_x_step <= STEP_W'(65536);
            r_y_step <= STEP_W'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PIXEL_FORMAT:  r_fmt    <= i_cfg_data[1:0];
                REG_SOURCE_WIDTH:  r_src_w  <= i_cfg_data[SIZE_W-1:0];
                REG_SOURCE_HEIGHT: r_src_h  <= i_cfg_data[SIZE_W-1:0];
                REG_X_STEP:        r_x_step <= i_cfg_data[STEP_W-1:0];
                REG_Y_STEP:        r_y_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // no internal stall: every cycle takes a beat
    assign o_busy = 1'b0;

    logic accept;
    assign accept = i_start && !o_busy;

    // stage 1: source position products, load data
    logic          r1_req, r1_load;
    logic [PW-1:0] r1_px, r1_py;
    logic [CW-1:0] r1_col;
    logic [RW-1:0] r1_row;
    logic [PIX_W-1:0] r1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_req  <= 1'b0;
            r1_load <= 1'b0;
        end else begin
            r1_req  <= accept && i_op;
            r1_load <= accept && !i_op && (32'(i_src_col) < MAX_SRC_WIDTH)
                       && (32'(i_src_row) < MAX_SRC_HEIGHT);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_px  <= PW'(i_dest_col) * PW'(r_x_step);
        r1_py  <= PW'(i_dest_row) * PW'(r_y_step);
        r1_col <= CW'(i_src_col);
        r1_row <= RW'(i_src_row);
        r1_pix <= i_in_pixel[PIX_W-1:0];
    end

    // clamp sizes to the store and find the last column and row
    logic [31:0]   w32, h32;
    logic [CW-1:0] wm1;
    logic [RW-1:0] hm1;
    assign w32 = (r_src_w == '0) ? 32'd1 :
                 ((32'(r_src_w) > MAX_SRC_WIDTH) ? 32'(MAX_SRC_WIDTH) : 32'(r_src_w));
    assign h32 = (r_src_h == '0) ? 32'd1 :
                 ((32'(r_src_h) > MAX_SRC_HEIGHT) ? 32'(MAX_SRC_HEIGHT) : 32'(r_src_h));
    assign wm1 = CW'(w32 - 32'd1);
    assign hm1 = RW'(h32 - 32'd1);

    // neighbour coordinates, saturated at the edges
    logic [IW-1:0] xi, yi;
    logic [CW-1:0] x1, x2;
    logic [RW-1:0] y1, y2;
    assign xi = r1_px[PW-1:FRAC_BITS];
    assign yi = r1_py[PW-1:FRAC_BITS];
    assign x1 = (xi >= IW'(wm1)) ? wm1 : xi[CW-1:0];
    assign y1 = (yi >= IW'(hm1)) ? hm1 : yi[RW-1:0];
    assign x2 = (x1 < wm1) ? x1 + CW'(1) : wm1;
    assign y2 = (y1 < hm1) ? y1 + RW'(1) : hm1;

    logic [AW-1:0] a11, a12, a21, a22, a_wr;
    assign a11  = AW'(y1) * ROW_PITCH + AW'(x1);
    assign a12  = AW'(y1) * ROW_PITCH + AW'(x2);
    assign a21  = AW'(y2) * ROW_PITCH + AW'(x1);
    assign a22  = AW'(y2) * ROW_PITCH + AW'(x2);
    assign a_wr = AW'(r1_row) * ROW_PITCH + AW'(r1_col);

    // two copies of the frame store, upper row pair and lower row pair
    logic [PIX_W-1:0] mem_top [DEPTH];
    logic [PIX_W-1:0] mem_bot [DEPTH];
    logic [PIX_W-1:0] r2_p11, r2_p12, r2_p21, r2_p22;

    always_ff @(posedge i_clk) begin
        if (r1_load) begin
            mem_top[a_wr] <= r1_pix;
        end
        r2_p11 <= mem_top[a11];
        r2_p12 <= mem_top[a12];
    end

    always_ff @(posedge i_clk) begin
        if (r1_load) begin
            mem_bot[a_wr] <= r1_pix;
        end
        r2_p21 <= mem_bot[a21];
        r2_p22 <= mem_bot[a22];
    end

    // stage 2: carry fractions alongside the read data
    logic                 r2_req;
    logic [FRAC_BITS-1:0] r2_fx, r2_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_req <= 1'b0;
        end else begin
            r2_req <= r1_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_fx <= r1_px[FRAC_BITS-1:0];
        r2_fy <= r1_py[FRAC_BITS-1:0];
    end

    // horizontal blend per channel
    t_rgb c11, c12, c21, c22;
    assign c11 = unpack_px(r_fmt, r2_p11);
    assign c12 = unpack_px(r_fmt, r2_p12);
    assign c21 = unpack_px(r_fmt, r2_p21);
    assign c22 = unpack_px(r_fmt, r2_p22);

    logic [FRAC_BITS:0] wx0, wx1;
    assign wx1 = {1'b0, r2_fx};
    assign wx0 = ONE_FRAC - wx1;

    logic                 r3_req;
    logic [TW-1:0]        r3_top [3];
    logic [TW-1:0]        r3_bot [3];
    logic [FRAC_BITS-1:0] r3_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_req <= 1'b0;
        end else begin
            r3_req <= r2_req;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r3_top[k] <= TW'(c11[k]) * TW'(wx0) + TW'(c12[k]) * TW'(wx1);
            r3_bot[k] <= TW'(c21[k]) * TW'(wx0) + TW'(c22[k]) * TW'(wx1);
        end
        r3_fy <= r2_fy;
    end

    // vertical blend, truncate and pack
    logic [FRAC_BITS:0] wy0, wy1;
    logic [VW-1:0]      vsum [3];
    t_rgb               res;
    assign wy1 = {1'b0, r3_fy};
    assign wy0 = ONE_FRAC - wy1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vsum[k] = VW'(r3_top[k]) * VW'(wy0) + VW'(r3_bot[k]) * VW'(wy1);
            res[k]  = vsum[k][2*FRAC_BITS +: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r3_req;
        end
    end

    always_ff @(posedge i_clk) begin
        o_out_pixel <= pack_px(r_fmt, res);
    end

endmodule

// File: sv/bis_checker.sv
module bis_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic i_op,
    input logic o_valid
);
    logic req_beat;
    assign req_beat = i_start && !o_busy && i_op;

    // every request beat yields a result once through the pipeline
    a_req_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_beat |-> ##4 o_valid)
        else $error("request beat without result");

    // no result without an earlier request beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(req_beat, 4))
        else $error("result without request");

    // a load beat never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_op) |-> ##4 !o_valid)
        else $error("result from load beat");

    // pipeline is empty right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result right after reset");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .i_op    (i_op),
    .o_valid (o_valid)
);
